/* src/maze_dfs_path_finder_assert.svh */
// ---------------------------------------------------------------------------
// maze_dfs_path_finder_assert.svh
// Assertion macros used by the maze path finder RTL.
// ---------------------------------------------------------------------------
`ifndef MAZE_DFS_PATH_FINDER_ASSERT_SVH
`define MAZE_DFS_PATH_FINDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mdfs_pkg.sv */
// ---------------------------------------------------------------------------
// mdfs_pkg
// Shared sizes, codes, command and status types of the maze path finder.
// ---------------------------------------------------------------------------
`default_nettype none
package mdfs_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CELL_W   = ROW_W + COL_W;
    localparam int GRID_SZ  = 2 ** CELL_W;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int STK_W    = $clog2(CELLS);
    localparam int DEPTH_W  = STK_W + 1;
    localparam int EFF_W    = 9;
    localparam int CNT_W    = 7;
    localparam int POS_W    = 6;
    localparam int IDX_W    = 12;
    localparam int LEN_W    = 13;
    localparam int HEAD_W   = 2;
    localparam int TURN_W   = 3;
    localparam int HT_W     = HEAD_W + TURN_W;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_SOLVE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_RSVD  = 2'd3
    } t_action;

    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic [HEAD_W-1:0] HD_DOWN  = 2'd0;
    localparam logic [HEAD_W-1:0] HD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HD_UP    = 2'd2;
    localparam logic [HEAD_W-1:0] HD_LEFT  = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_WRITE,
        CMD_BAD,
        CMD_SOLVE_FAIL,
        CMD_CLEAR_BEGIN,
        CMD_CLEAR_STEP,
        CMD_SEED,
        CMD_TRY,
        CMD_POP,
        CMD_POP_LAST,
        CMD_LOAD_TOP,
        CMD_VIS_READ,
        CMD_PUSH,
        CMD_PUSH_GOAL,
        CMD_READ_ISSUE
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    solve_ok;
        logic    same;
        logic    clr_last;
        logic    turn_done;
        logic    depth_one;
        logic    blocked;
        logic    next_is_goal;
        logic    visited;
    } t_status;

    // right, straight, left, reverse relative to the heading
    function automatic logic [HEAD_W-1:0] turn_offset(input logic [1:0] t);
        logic [HEAD_W-1:0] o;
        unique case (t)
            2'd0:    o = 2'd3;
            2'd1:    o = 2'd0;
            2'd2:    o = 2'd1;
            default: o = 2'd2;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

/* src/maze_dfs_path_finder.sv */
// ---------------------------------------------------------------------------
// maze_dfs_path_finder
// Depth-first maze solver with wall store, visited map and path stack.
// ---------------------------------------------------------------------------
// Usage:
//   Raise i_start with the item fields while o_busy is low; the word is taken
//   on that edge and o_busy rises. i_action selects a wall write, a solve or a
//   path read. Exactly one result word follows, shown for one cycle with
//   o_done high; the receiver cannot stall, so sample it then.
//   Sequence: a write, a rejected solve or an unused action steps from the
//   decode state to the result state; a read steps through decode, a path
//   RAM read state and then the result state. The next word can be taken in
//   the cycle after the result cycle. A solve first sweeps the visited map,
//   one cell a cycle across the whole 64 x 64 grid, then walks: each tried
//   direction passes through a wall RAM read and, when open and not the
//   goal, a visited RAM read; each backtrack is a pop and a top reload.
//   o_found and o_path_length always reflect the latest solve.
//   Config: write i_cfg_wdata to register i_cfg_index (0 rows, 1 columns)
//   while idle. Reset returns counts to 64, clears found and depth; the wall
//   memory holds garbage until written.
// ---------------------------------------------------------------------------
`default_nettype none
`include "maze_dfs_path_finder_assert.svh"
module maze_dfs_path_finder
    import mdfs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_index,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic [1:0]       i_action,
    input  wire logic [POS_W-1:0] i_cell_row,
    input  wire logic [POS_W-1:0] i_cell_col,
    input  wire logic [1:0]       i_wall_bits,
    input  wire logic [POS_W-1:0] i_start_row,
    input  wire logic [POS_W-1:0] i_start_col,
    input  wire logic [POS_W-1:0] i_goal_row,
    input  wire logic [POS_W-1:0] i_goal_col,
    input  wire logic [IDX_W-1:0] i_path_index,
    output logic                  o_done,
    output logic                  o_found,
    output logic      [LEN_W-1:0] o_path_length,
    output logic      [POS_W-1:0] o_path_row,
    output logic      [POS_W-1:0] o_path_col,
    output logic                  o_error
);
    t_cmd    cmd;
    t_status status;

    // sequencer: decode, clear sweep, walk steps, response
    mdfs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_status(status), .o_cmd(cmd), .o_busy(o_busy), .o_done(o_done)
    );

    // memories, top-of-stack registers and result word
    mdfs_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_action(i_action), .i_cell_row(i_cell_row), .i_cell_col(i_cell_col),
        .i_wall_bits(i_wall_bits), .i_start_row(i_start_row), .i_start_col(i_start_col),
        .i_goal_row(i_goal_row), .i_goal_col(i_goal_col), .i_path_index(i_path_index),
        .o_status(status), .o_found(o_found), .o_path_length(o_path_length),
        .o_path_row(o_path_row), .o_path_col(o_path_col), .o_error(o_error)
    );

    // an accepted word keeps the block busy until its result
    `MDFS_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "accept did not raise busy")
    // the result strobe lasts one cycle and releases the block
    `MDFS_ASSERT_NEXT(a_done_release, o_done, !o_done && !o_busy, "done strobe not single")
    // a result only appears while an item is in flight
    `MDFS_ASSERT_NOW(a_done_busy, o_done, o_busy, "done outside an item")
    // no path length is reported without a found path
    `MDFS_ASSERT_NOW(a_len_found, !o_found, o_path_length == '0, "length without found")
endmodule
`default_nettype wire

/* src/mdfs_ram.sv */
// ---------------------------------------------------------------------------
// mdfs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module mdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/mdfs_ctrl.sv */
// ---------------------------------------------------------------------------
// mdfs_ctrl
// Sequencer of the maze walk: decodes items and steps the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module mdfs_ctrl
    import mdfs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_done
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CLEAR, S_SEED, S_EXPAND, S_WALL, S_VIS, S_POPLD, S_READ, S_RESP
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.action)
                    ACT_WRITE: begin
                        o_cmd   = CMD_WRITE;
                        n_state = S_RESP;
                    end
                    ACT_SOLVE: begin
                        if (i_status.solve_ok) begin
                            o_cmd   = CMD_CLEAR_BEGIN;
                            n_state = S_CLEAR;
                        end else begin
                            o_cmd   = CMD_SOLVE_FAIL;
                            n_state = S_RESP;
                        end
                    end
                    ACT_READ: begin
                        o_cmd   = CMD_READ_ISSUE;
                        n_state = S_READ;
                    end
                    default: begin
                        o_cmd   = CMD_BAD;
                        n_state = S_RESP;
                    end
                endcase
            end
            S_CLEAR: begin
                o_cmd = CMD_CLEAR_STEP;
                if (i_status.clr_last) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd   = CMD_SEED;
                n_state = i_status.same ? S_RESP : S_EXPAND;
            end
            S_EXPAND: begin
                priority if (!i_status.turn_done) begin
                    o_cmd   = CMD_TRY;
                    n_state = S_WALL;
                end else if (i_status.depth_one) begin
                    o_cmd   = CMD_POP_LAST;
                    n_state = S_RESP;
                end else begin
                    o_cmd   = CMD_POP;
                    n_state = S_POPLD;
                end
            end
            S_POPLD: begin
                o_cmd   = CMD_LOAD_TOP;
                n_state = S_EXPAND;
            end
            S_WALL: begin
                priority if (i_status.blocked) begin
                    n_state = S_EXPAND;
                end else if (i_status.next_is_goal) begin
                    o_cmd   = CMD_PUSH_GOAL;
                    n_state = S_RESP;
                end else begin
                    o_cmd   = CMD_VIS_READ;
                    n_state = S_VIS;
                end
            end
            S_VIS: begin
                if (!i_status.visited) begin
                    o_cmd = CMD_PUSH;
                end
                n_state = S_EXPAND;
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);
endmodule
`default_nettype wire

/* src/mdfs_dp.sv */
// ---------------------------------------------------------------------------
// mdfs_dp
// Datapath of the maze walk: wall, visited and stack memories, top entry.
// ---------------------------------------------------------------------------
`default_nettype none
module mdfs_dp
    import mdfs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_index,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic [1:0]       i_action,
    input  wire logic [POS_W-1:0] i_cell_row,
    input  wire logic [POS_W-1:0] i_cell_col,
    input  wire logic [1:0]       i_wall_bits,
    input  wire logic [POS_W-1:0] i_start_row,
    input  wire logic [POS_W-1:0] i_start_col,
    input  wire logic [POS_W-1:0] i_goal_row,
    input  wire logic [POS_W-1:0] i_goal_col,
    input  wire logic [IDX_W-1:0] i_path_index,
    output t_status               o_status,
    output logic                  o_found,
    output logic      [LEN_W-1:0] o_path_length,
    output logic      [POS_W-1:0] o_path_row,
    output logic      [POS_W-1:0] o_path_col,
    output logic                  o_error
);
    // configuration
    logic [CNT_W-1:0] r_row_count, r_column_count;
    logic [EFF_W-1:0] rows_eff, cols_eff;

    // latched item
    logic [1:0]       r_action;
    logic [POS_W-1:0] r_cell_row, r_cell_col, r_start_row, r_start_col, r_goal_row, r_goal_col;
    logic [1:0]       r_wall_bits;
    logic [IDX_W-1:0] r_path_index;

    // walk state
    logic [ROW_W-1:0]   r_cur_r, r_nr;
    logic [COL_W-1:0]   r_cur_c, r_nc;
    logic [HEAD_W-1:0]  r_head, r_h;
    logic [TURN_W-1:0]  r_turn;
    logic               r_edge;
    logic [DEPTH_W-1:0] r_depth;
    logic [CELL_W-1:0]  r_clr;
    logic               r_found;
    logic [POS_W-1:0]   r_prow, r_pcol;
    logic               r_err;

    logic write_ok, solve_ok, read_ok;
    logic [ROW_W-1:0]  start_r, goal_r;
    logic [COL_W-1:0]  start_c, goal_c;
    logic [HEAD_W-1:0] try_h;
    logic              try_edge;
    logic [ROW_W-1:0]  try_nr;
    logic [COL_W-1:0]  try_nc;

    logic              wall_we, vis_we, path_we, ht_we;
    logic [CELL_W-1:0] wall_raddr, vis_addr, path_wdata;
    logic [1:0]        wall_rdata;
    logic [0:0]        vis_wdata, vis_rdata;
    logic [STK_W-1:0]  path_waddr, path_raddr, ht_waddr;
    logic [CELL_W-1:0] path_rdata;
    logic [HT_W-1:0]   ht_rdata;
    logic [DEPTH_W-1:0] read_n;

    function automatic logic [EFF_W-1:0] eff_count(input logic [CNT_W-1:0] c, input int mx);
        logic [EFF_W-1:0] v;
        if (c == '0) begin
            v = EFF_W'(1);
        end else if (int'(c) > mx) begin
            v = EFF_W'(mx);
        end else begin
            v = EFF_W'(c);
        end
        return v;
    endfunction

    assign rows_eff = eff_count(r_row_count, MAX_ROWS);
    assign cols_eff = eff_count(r_column_count, MAX_COLS);

    assign write_ok = (EFF_W'(r_cell_row) < rows_eff) && (EFF_W'(r_cell_col) < cols_eff);
    assign solve_ok = (EFF_W'(r_start_row) < rows_eff) && (EFF_W'(r_start_col) < cols_eff)
                   && (EFF_W'(r_goal_row) < rows_eff) && (EFF_W'(r_goal_col) < cols_eff);
    assign read_n   = r_found ? r_depth : '0;
    assign read_ok  = (DEPTH_W'(r_path_index) < read_n) && (int'(r_path_index) < CELLS);

    assign start_r = ROW_W'(r_start_row);
    assign start_c = COL_W'(r_start_col);
    assign goal_r  = ROW_W'(r_goal_row);
    assign goal_c  = COL_W'(r_goal_col);

    // candidate heading and neighbor of the top cell
    always_comb begin
        try_h      = r_head + turn_offset(r_turn[1:0]);
        try_nr     = r_cur_r;
        try_nc     = r_cur_c;
        wall_raddr = {r_cur_r, r_cur_c};
        unique case (try_h)
            HD_DOWN: begin
                try_edge = (EFF_W'(r_cur_r) + EFF_W'(1)) >= rows_eff;
                try_nr   = r_cur_r + ROW_W'(1);
            end
            HD_RIGHT: begin
                try_edge = (EFF_W'(r_cur_c) + EFF_W'(1)) >= cols_eff;
                try_nc   = r_cur_c + COL_W'(1);
            end
            HD_UP: begin
                try_edge   = (r_cur_r == '0);
                try_nr     = r_cur_r - ROW_W'(1);
                wall_raddr = {try_nr, r_cur_c};
            end
            default: begin
                try_edge   = (r_cur_c == '0);
                try_nc     = r_cur_c - COL_W'(1);
                wall_raddr = {r_cur_r, try_nc};
            end
        endcase
    end

    // memory port steering
    always_comb begin
        wall_we    = (i_cmd == CMD_WRITE) && write_ok;
        vis_we     = 1'b0;
        vis_addr   = {r_nr, r_nc};
        vis_wdata  = 1'b1;
        path_we    = 1'b0;
        path_waddr = STK_W'(r_depth);
        path_wdata = {r_nr, r_nc};
        path_raddr = STK_W'(r_depth - DEPTH_W'(2));
        ht_we      = 1'b0;
        ht_waddr   = STK_W'(r_depth - DEPTH_W'(1));
        unique case (i_cmd)
            CMD_CLEAR_STEP: begin
                vis_we    = 1'b1;
                vis_addr  = r_clr;
                vis_wdata = 1'b0;
            end
            CMD_SEED: begin
                vis_we     = (r_start_row != r_goal_row) || (r_start_col != r_goal_col);
                vis_addr   = {start_r, start_c};
                path_we    = 1'b1;
                path_wdata = {start_r, start_c};
            end
            CMD_PUSH: begin
                vis_we  = 1'b1;
                path_we = 1'b1;
                ht_we   = 1'b1;
            end
            CMD_PUSH_GOAL: begin
                path_we = 1'b1;
                ht_we   = 1'b1;
            end
            CMD_READ_ISSUE: begin
                path_raddr = STK_W'(r_path_index);
            end
            default: begin
            end
        endcase
    end

    mdfs_ram #(.WIDTH(2), .DEPTH(GRID_SZ)) u_walls (
        .i_clk(i_clk), .i_we(wall_we), .i_waddr({ROW_W'(r_cell_row), COL_W'(r_cell_col)}),
        .i_wdata(r_wall_bits), .i_raddr(wall_raddr), .o_rdata(wall_rdata)
    );

    mdfs_ram #(.WIDTH(1), .DEPTH(GRID_SZ)) u_visited (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_addr),
        .i_wdata(vis_wdata), .i_raddr({r_nr, r_nc}), .o_rdata(vis_rdata)
    );

    mdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_waddr),
        .i_wdata(path_wdata), .i_raddr(path_raddr), .o_rdata(path_rdata)
    );

    mdfs_ram #(.WIDTH(HT_W), .DEPTH(CELLS)) u_heading_turn (
        .i_clk(i_clk), .i_we(ht_we), .i_waddr(ht_waddr),
        .i_wdata({r_head, r_turn}), .i_raddr(path_raddr), .o_rdata(ht_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= CNT_W'(64);
            r_column_count <= CNT_W'(64);
            r_depth        <= '0;
            r_found        <= 1'b0;
            r_err          <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ROW_COUNT:    r_row_count    <= i_cfg_wdata;
                    default:          r_column_count <= i_cfg_wdata;
                endcase
            end
            unique case (i_cmd)
                CMD_WRITE:       r_err <= !write_ok;
                CMD_BAD:         r_err <= 1'b1;
                CMD_SOLVE_FAIL: begin
                    r_err   <= 1'b1;
                    r_depth <= '0;
                    r_found <= 1'b0;
                end
                CMD_CLEAR_BEGIN: begin
                    r_err   <= 1'b0;
                    r_depth <= '0;
                    r_found <= 1'b0;
                end
                CMD_SEED: begin
                    r_depth <= DEPTH_W'(1);
                    r_found <= (r_start_row == r_goal_row) && (r_start_col == r_goal_col);
                end
                CMD_POP, CMD_POP_LAST: r_depth <= r_depth - DEPTH_W'(1);
                CMD_PUSH:        r_depth <= r_depth + DEPTH_W'(1);
                CMD_PUSH_GOAL: begin
                    r_depth <= r_depth + DEPTH_W'(1);
                    r_found <= 1'b1;
                end
                CMD_READ_ISSUE:  r_err <= !read_ok;
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LATCH: begin
                r_action     <= i_action;
                r_cell_row   <= i_cell_row;
                r_cell_col   <= i_cell_col;
                r_wall_bits  <= i_wall_bits;
                r_start_row  <= i_start_row;
                r_start_col  <= i_start_col;
                r_goal_row   <= i_goal_row;
                r_goal_col   <= i_goal_col;
                r_path_index <= i_path_index;
                r_prow       <= '0;
                r_pcol       <= '0;
            end
            CMD_CLEAR_BEGIN: r_clr <= '0;
            CMD_CLEAR_STEP:  r_clr <= r_clr + CELL_W'(1);
            CMD_SEED: begin
                r_cur_r <= start_r;
                r_cur_c <= start_c;
                r_head  <= HD_DOWN;
                r_turn  <= '0;
            end
            CMD_TRY: begin
                r_turn <= r_turn + TURN_W'(1);
                r_h    <= try_h;
                r_edge <= try_edge;
                r_nr   <= try_nr;
                r_nc   <= try_nc;
            end
            CMD_LOAD_TOP: begin
                {r_cur_r, r_cur_c} <= path_rdata;
                {r_head, r_turn}   <= ht_rdata;
            end
            CMD_PUSH, CMD_PUSH_GOAL: begin
                r_cur_r <= r_nr;
                r_cur_c <= r_nc;
                r_head  <= r_h;
                r_turn  <= '0;
            end
            default: begin
            end
        endcase
        // read data lands the cycle after the read is issued
        if (i_cmd == CMD_NONE && r_action == ACT_READ && !r_err) begin
            r_prow <= POS_W'(path_rdata[CELL_W-1:COL_W]);
            r_pcol <= POS_W'(path_rdata[COL_W-1:0]);
        end
    end

    always_comb begin
        o_status.action       = t_action'(r_action);
        o_status.solve_ok     = solve_ok;
        o_status.same         = (r_start_row == r_goal_row) && (r_start_col == r_goal_col);
        o_status.clr_last     = &r_clr;
        o_status.turn_done    = r_turn >= ((r_depth == DEPTH_W'(1)) ? TURN_W'(4) : TURN_W'(3));
        o_status.depth_one    = (r_depth == DEPTH_W'(1));
        o_status.blocked      = r_edge
                              | (((r_h == HD_DOWN) || (r_h == HD_UP)) ? wall_rdata[1] : wall_rdata[0]);
        o_status.next_is_goal = (r_nr == goal_r) && (r_nc == goal_c);
        o_status.visited      = vis_rdata[0];
    end

    assign o_found       = r_found;
    assign o_path_length = r_found ? LEN_W'(r_depth) : '0;
    assign o_path_row    = r_prow;
    assign o_path_col    = r_pcol;
    assign o_error       = r_err;
endmodule
`default_nettype wire
